/* sv/dtq_pkg.sv */
// Package for the deadline timer queue: sizes, action and result codes,
// beat layouts, controller state type and the controller/datapath structs.
// No dependencies.
package dtq_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int MAX_FIRE  = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int SCNT_W    = $clog2(SLOTS + 1);
  localparam int FCNT_W    = $clog2(MAX_FIRE + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [SCNT_W-1:0]    scnt_t;

  localparam logic [2:0] ACT_SCHEDULE = 3'd0;
  localparam logic [2:0] ACT_RESTART  = 3'd1;
  localparam logic [2:0] ACT_CANCEL   = 3'd2;
  localparam logic [2:0] ACT_QUERY    = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;

  localparam logic [2:0] KIND_SCHEDULED = 3'd0;
  localparam logic [2:0] KIND_FIRED     = 3'd1;
  localparam logic [2:0] KIND_FULL      = 3'd2;
  localparam logic [2:0] KIND_RESTARTED = 3'd3;
  localparam logic [2:0] KIND_CANCELLED = 3'd4;
  localparam logic [2:0] KIND_NOTFOUND  = 3'd5;
  localparam logic [2:0] KIND_PENDING   = 3'd6;
  localparam logic [2:0] KIND_GONE      = 3'd7;

  // beat layouts of the input and result channels
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] timer_id;
    logic [15:0] delay_ms;
    logic        periodic;
    logic        immediate;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] result_id;
    logic        last;
  } res_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT,
    ST_FIRE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat, clear scan
    logic tick;       // advance time (with load)
    logic scan;       // visit slot scan_idx
    logic apply;      // commit command result
    logic fire;       // commit best candidate, restart scan
    logic emit_last;  // mark the held fire beat as the closing one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // all slots visited
    logic have_best;  // tick scan found a due slot
  } stat_t;

endpackage

/* sv/dtq_if.sv */
// Valid/ready channel interface carrying one beat of payload.
// Depends on nothing; payload type is a parameter.
interface dtq_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/dtq_ctrl.sv */
// Controller state machine of the deadline timer queue.
// Depends on dtq_pkg.
module dtq_ctrl import dtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);
  state_t state, state_next;
  logic is_tick, is_tick_next;
  logic [FCNT_W-1:0] nfire, nfire_next;

  wire take = in_valid && in_ready;
  wire known = in_action <= ACT_TICK;
  wire cap_fire = nfire == FCNT_W'(MAX_FIRE - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (take && known) state_next = ST_SCAN;
      ST_SCAN:  if (stat.scan_done) begin
        if (!is_tick) state_next = ST_APPLY;
        else if (stat.have_best) state_next = (nfire == '0) ? ST_FIRE : ST_EMIT;
        else if (nfire != '0) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_APPLY: state_next = ST_EMIT;
      ST_FIRE:  state_next = cap_fire ? ST_EMIT : ST_SCAN;
      ST_EMIT:  if (out_ready) begin
        if (is_tick && stat.have_best) state_next = ST_FIRE;
        else state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    is_tick_next = is_tick;
    nfire_next = nfire;
    if (state == ST_IDLE && take) begin
      is_tick_next = in_action == ACT_TICK;
      nfire_next = '0;
    end
    if (state == ST_FIRE) nfire_next = nfire + 1'b1;
  end

  // last fire: burst cap reached, or the lookahead scan after a fire finds
  // nothing due; the held fire beat is marked before it is released
  always_comb begin
    cmd = '0;
    in_ready = state == ST_IDLE;
    out_valid = state == ST_EMIT;
    cmd.load = state == ST_IDLE && take;
    cmd.tick = cmd.load && in_action == ACT_TICK;
    cmd.scan = state == ST_SCAN;
    cmd.apply = state == ST_APPLY;
    cmd.fire = state == ST_FIRE;
    cmd.emit_last = (state == ST_SCAN && stat.scan_done && is_tick &&
                     !stat.have_best && nfire != '0) ||
                    (state == ST_FIRE && cap_fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      is_tick <= 1'b0;
      nfire <= '0;
    end else begin
      state <= state_next;
      is_tick <= is_tick_next;
      nfire <= nfire_next;
    end
  end

  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_EMIT) else $error("out_valid outside emit");
  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    nfire <= FCNT_W'(MAX_FIRE)) else $error("fire count overflow");
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

/* sv/dtq_dp.sv */
// Datapath: slot table, time and ID counters, sequential slot scan and
// result register. Depends on dtq_pkg.
module dtq_dp import dtq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_timer_id,
  input  logic [15:0] in_delay_ms,
  input  logic        in_periodic,
  input  logic        in_immediate,
  output logic [2:0]  kind,
  output logic [15:0] result_id,
  output logic        last
);
  logic [SLOTS-1:0] slot_valid, due;
  logic             slot_periodic [SLOTS];
  logic [15:0]      slot_delay [SLOTS];
  time_t            slot_deadline [SLOTS];
  logic [15:0]      slot_ident [SLOTS];
  logic [15:0]      next_ident;
  time_t            now_time;

  logic [2:0]  act;
  logic [15:0] tid, dly;
  logic        per, imm;
  scnt_t       scan_idx;
  logic        found;
  slot_t       hit;
  logic        have_best;
  slot_t       best;
  time_t       best_age;
  logic [15:0] best_idage;

  wire slot_t i = scan_idx[SLOT_W-1:0];
  wire time_t age = now_time - slot_deadline[i];
  wire logic [15:0] idage = next_ident - slot_ident[i];
  wire logic hit_now = act == ACT_SCHEDULE ? !slot_valid[i]
                     : slot_valid[i] && slot_ident[i] == tid;
  wire logic due_now = due[i] && !age[TIME_BITS-1];

  assign stat.scan_done = scan_idx == scnt_t'(SLOTS);
  assign stat.have_best = have_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      next_ident <= '0;
      now_time <= '0;
      scan_idx <= '0;
      found <= 1'b0;
      have_best <= 1'b0;
      due <= '0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        found <= 1'b0;
        have_best <= 1'b0;
        due <= slot_valid;
        if (cmd.tick) now_time <= now_time + 1'b1;
      end
      if (cmd.scan && !stat.scan_done) begin
        scan_idx <= scan_idx + 1'b1;
        if (act == ACT_TICK) begin
          if (due_now && (!have_best || age > best_age ||
              (age == best_age && idage > best_idage))) begin
            have_best <= 1'b1;
            best <= i;
            best_age <= age;
            best_idage <= idage;
          end
        end else if (hit_now && !found) begin
          found <= 1'b1;
          hit <= i;
        end
      end
      if (cmd.apply && found) begin
        case (act)
          ACT_SCHEDULE: begin
            slot_valid[hit] <= 1'b1;
            slot_periodic[hit] <= per;
            slot_delay[hit] <= dly;
            slot_deadline[hit] <= now_time + (imm ? '0 : time_t'(dly));
            slot_ident[hit] <= next_ident;
            next_ident <= next_ident + 1'b1;
          end
          ACT_RESTART: slot_deadline[hit] <= now_time + time_t'(slot_delay[hit]);
          ACT_CANCEL:  slot_valid[hit] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.fire) begin
        due[best] <= 1'b0;
        if (slot_periodic[best])
          slot_deadline[best] <= now_time + time_t'(slot_delay[best]);
        else slot_valid[best] <= 1'b0;
        scan_idx <= '0;
        have_best <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_action;
      tid <= in_timer_id;
      dly <= in_delay_ms;
      per <= in_periodic;
      imm <= in_immediate;
    end
    if (cmd.apply) begin
      last <= 1'b1;
      result_id <= (act == ACT_SCHEDULE) ? (found ? next_ident : 16'd0) : tid;
      case (act)
        ACT_SCHEDULE: kind <= found ? KIND_SCHEDULED : KIND_FULL;
        ACT_RESTART:  kind <= found ? KIND_RESTARTED : KIND_NOTFOUND;
        ACT_CANCEL:   kind <= found ? KIND_CANCELLED : KIND_NOTFOUND;
        default:      kind <= found ? KIND_PENDING : KIND_GONE;
      endcase
    end else if (cmd.fire) begin
      kind <= KIND_FIRED;
      result_id <= slot_ident[best];
      last <= cmd.emit_last;
    end else if (cmd.emit_last) begin
      last <= 1'b1;
    end
  end

  a_apply_scanned: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> stat.scan_done) else $error("apply before scan end");
  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> have_best && slot_valid[best]) else $error("fire of empty slot");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_idx <= scnt_t'(SLOTS)) else $error("scan index overrun");
endmodule

/* sv/deadline_timer_queue.sv */
// Top level of the deadline timer queue: joins the controller and datapath.
// Depends on dtq_pkg, dtq_if, dtq_ctrl and dtq_dp.
//
// Usage: one input channel (in) carries command beats: action, timer_id,
// delay_ms, periodic, immediate. One output channel (out) carries result
// beats: kind, result_id, last. Schedule, restart, cancel and query give
// one result with last set. A tick advances time by one and gives one fired
// beat per due timer, oldest deadline first, at most 16 per tick.
// Each command makes one scan through the table, then an apply step and
// its result beat. A tick makes a first scan, then for each fired timer a
// commit, a lookahead scan and a result beat; the commit that reaches the
// cap goes straight to its result beat.
// A new item is taken only after all beats of the previous one are out.
// Reset clears all slot valid bits, the time and the ID counter. When the
// receiver stalls, the current result beat holds and the scan halts; no
// input is taken until the stall clears.
// The last flag of a tick burst is set on its 16th beat, or on the beat
// after which a scan before its release finds nothing more due.
module deadline_timer_queue import dtq_pkg::*; (
  input logic clk,
  input logic rst,
  dtq_if.sink   in,
  dtq_if.source out
);
  cmd_t  cmd;
  stat_t stat;
  logic  out_valid;
  logic [2:0]  kind;
  logic [15:0] result_id;
  logic        last;

  dtq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in.valid),
    .in_ready (in.ready),
    .in_action(in.data.action),
    .out_valid(out_valid),
    .out_ready(out.ready),
    .stat, .cmd
  );

  dtq_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .in_action   (in.data.action),
    .in_timer_id (in.data.timer_id),
    .in_delay_ms (in.data.delay_ms),
    .in_periodic (in.data.periodic),
    .in_immediate(in.data.immediate),
    .kind, .result_id, .last
  );

  assign out.valid = out_valid;
  assign out.data.kind = kind;
  assign out.data.result_id = result_id;
  assign out.data.last = last;
endmodule
